>>> src/pmrd_pkg.sv
// -----------------------------------------------------------------------------
// Power MCU register device package
// Shared types and constants: opcodes, register map, transaction structs.
// -----------------------------------------------------------------------------
package pmrd_pkg;

   localparam int DATA_W  = 8;
   localparam int EVENT_W = 32;

   typedef enum logic [1:0] {
      OP_SET_PTR = 2'd0,
      OP_WRITE   = 2'd1,
      OP_READ    = 2'd2,
      OP_EVENT   = 2'd3
   } op_type;

   // register map
   localparam logic [7:0] ADDR_ID0       = 8'h00;
   localparam logic [7:0] ADDR_ID1       = 8'h01;
   localparam logic [7:0] ADDR_BATTERY   = 8'h0B;
   localparam logic [7:0] ADDR_RAIL_STAT = 8'h0F;
   localparam logic [7:0] ADDR_FLAG0     = 8'h10;
   localparam logic [7:0] ADDR_FLAG1     = 8'h11;
   localparam logic [7:0] ADDR_FLAG2     = 8'h12;
   localparam logic [7:0] ADDR_FLAG3     = 8'h13;
   localparam logic [7:0] ADDR_MASK0     = 8'h18;
   localparam logic [7:0] ADDR_MASK1     = 8'h19;
   localparam logic [7:0] ADDR_MASK2     = 8'h1A;
   localparam logic [7:0] ADDR_MASK3     = 8'h1B;
   localparam logic [7:0] ADDR_RAIL_CTRL = 8'h22;
   localparam logic [7:0] ADDR_RAM_IDX   = 8'h60;
   localparam logic [7:0] ADDR_RAM_DATA  = 8'h61;

   // pointer values that turn auto-increment off
   localparam logic [7:0] NOINC_A = 8'h29;
   localparam logic [7:0] NOINC_B = 8'h2D;
   localparam logic [7:0] NOINC_C = 8'h4F;
   localparam logic [7:0] NOINC_D = 8'h61;
   localparam logic [7:0] NOINC_E = 8'h7F;

   localparam logic [7:0] ID_BYTE0       = 8'h13;
   localparam logic [7:0] ID_BYTE1       = 8'h41;
   localparam logic [7:0] RAIL_STAT_BASE = 8'h02;
   localparam logic [7:0] BATTERY_RESET  = 8'h64;
   localparam logic [5:0] RAIL_FLAG_BITS = 6'h3F;

   typedef struct packed {
      op_type              opcode;
      logic [DATA_W-1:0]   data_byte;
      logic [EVENT_W-1:0]  event_mask;
   } pmrd_item_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_byte;
      logic                irq_request;
      logic [DATA_W-1:0]   rail_state;
   } pmrd_result_type;

endpackage

>>> src/pmrd_req_if.sv
// -----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one register access transaction.
// -----------------------------------------------------------------------------
interface pmrd_req_if;
   import pmrd_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [DATA_W-1:0]   data_byte;
   logic [EVENT_W-1:0]  event_mask;

   modport source (output valid, output opcode, output data_byte, output event_mask,
                   input ready);
   modport sink   (input valid, input opcode, input data_byte, input event_mask,
                   output ready);
endinterface

>>> src/pmrd_rsp_if.sv
// -----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one result transaction.
// -----------------------------------------------------------------------------
interface pmrd_rsp_if;
   import pmrd_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_byte;
   logic                irq_request;
   logic [DATA_W-1:0]   rail_state;

   modport source (output valid, output read_byte, output irq_request, output rail_state,
                   input ready);
   modport sink   (input valid, input read_byte, input irq_request, input rail_state,
                   output ready);
endinterface

>>> src/power_mcu_register_device_core.sv
// Path: a transaction accepted into the input register is executed into the result
//   register, which then presents it on the response channel.
// Throughput: one transaction per cycle; the input register, the execute stage and the
//   result register all move together whenever the result side is not stalled.
// Reset: synchronous, active high; clears pointer, flags, mask, rails, RAM index and the
//   RAM valid bits at once (no clearing pass), battery level returns to 100.
// -----------------------------------------------------------------------------
// Power MCU register device core
// Byte-wide register device with interrupt flags, rail control and scratch RAM.
// -----------------------------------------------------------------------------
module power_mcu_register_device_core #(
   parameter int RAM_BYTES = 200
) (
   input  logic                         clock,
   input  logic                         reset,
   pmrd_req_if.sink                     req_bus,
   pmrd_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [pmrd_pkg::DATA_W-1:0]  csr_wr_data
);
   import pmrd_pkg::*;

   // battery level register, written from the CSR port
   logic [DATA_W-1:0]  battery_ff;

   // input register stage
   logic               a_valid_ff, a_valid_in;
   pmrd_item_type      a_item_ff;

   // result register stage (payload lives in the register file)
   logic               b_valid_ff, b_valid_in;

   logic               req_fire;
   logic               exec;
   pmrd_result_type    result;

   // The input stage executes when the result register is free or draining this cycle.
   assign exec          = a_valid_ff && (!b_valid_ff || rsp_bus.ready);
   // A new transaction is taken whenever the input register is empty or moving on,
   // even while a finished result waits at the output.
   assign req_bus.ready = !a_valid_ff || exec;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign a_valid_in = req_fire || (a_valid_ff && !exec);
   assign b_valid_in = exec || (b_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         battery_ff <= BATTERY_RESET;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (csr_wr_en) begin
            battery_ff <= csr_wr_data;
         end
      end
   end

   // transaction payload capture; no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff.opcode     <= op_type'(req_bus.opcode);
         a_item_ff.data_byte  <= req_bus.data_byte;
         a_item_ff.event_mask <= req_bus.event_mask;
      end
   end

   // All state updates apart from the battery level, and the result register, sit behind
   // this boundary; each exec consumes exactly one transaction and loads exactly one result.
   pmrd_regfile #(
      .RAM_BYTES (RAM_BYTES)
   ) u_regfile (
      .clock         (clock),
      .reset         (reset),
      .exec          (exec),
      .item          (a_item_ff),
      .battery_level (battery_ff),
      .result        (result)
   );

   assign rsp_bus.valid       = b_valid_ff;
   assign rsp_bus.read_byte   = result.read_byte;
   assign rsp_bus.irq_request = result.irq_request;
   assign rsp_bus.rail_state  = result.rail_state;

endmodule

>>> src/pmrd_regfile.sv
// -----------------------------------------------------------------------------
// Register file and execute stage
// Device state, scratch RAM and the result register, updated once per exec.
// -----------------------------------------------------------------------------
module pmrd_regfile #(
   parameter int RAM_BYTES = 200
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       exec,
   input  pmrd_pkg::pmrd_item_type    item,
   input  logic [pmrd_pkg::DATA_W-1:0] battery_level,
   output pmrd_pkg::pmrd_result_type  result
);
   import pmrd_pkg::*;

   localparam int         RAM_AW    = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
   localparam logic [8:0] RAM_LIMIT = 9'(RAM_BYTES);

   logic [7:0]            ptr_ff, ptr_in;
   logic                  autoinc_ff, autoinc_in;
   logic [EVENT_W-1:0]    flags_ff, flags_in;
   logic [EVENT_W-1:0]    mask_ff, mask_in;
   logic [7:0]            rails_ff, rails_in;
   logic [7:0]            ram_idx_ff, ram_idx_in;
   logic [RAM_BYTES-1:0]  ram_valid_ff;

   logic [7:0]            ram_mem [RAM_BYTES];
   logic [7:0]            ram_rd_ff;
   logic                  ram_hit_ff, ram_hit_in;
   logic [7:0]            rbyte_ff, rbyte_in;
   logic                  irq_ff, irq_in;
   logic [7:0]            rail_out_ff;

   logic                  ram_we;
   logic                  ram_in_range;
   logic [RAM_AW-1:0]     ram_addr;
   logic [1:0]            byte_sel;
   logic [7:0]            d;

   assign d            = item.data_byte;
   assign byte_sel     = ptr_ff[1:0];
   assign ram_addr     = ram_idx_ff[RAM_AW-1:0];
   assign ram_in_range = ({1'b0, ram_idx_ff} < RAM_LIMIT);

   always_comb begin
      ptr_in     = ptr_ff;
      autoinc_in = autoinc_ff;
      flags_in   = flags_ff;
      mask_in    = mask_ff;
      rails_in   = rails_ff;
      ram_idx_in = ram_idx_ff;
      ram_we     = 1'b0;
      ram_hit_in = 1'b0;
      rbyte_in   = '0;
      irq_in     = 1'b0;

      unique case (item.opcode)
         OP_SET_PTR: begin
            ptr_in     = d;
            autoinc_in = !(d == NOINC_A || d == NOINC_B || d == NOINC_C ||
                           d == NOINC_D || d == NOINC_E);
         end
         OP_READ: begin
            ptr_in = ptr_ff + {7'd0, autoinc_ff};
            unique case (ptr_ff)
               ADDR_ID0:       rbyte_in = ID_BYTE0;
               ADDR_ID1:       rbyte_in = ID_BYTE1;
               ADDR_BATTERY:   rbyte_in = battery_level;
               ADDR_RAIL_STAT: rbyte_in = RAIL_STAT_BASE | rails_ff;
               ADDR_FLAG0, ADDR_FLAG1, ADDR_FLAG2, ADDR_FLAG3: begin
                  // read-to-clear of one flag byte
                  rbyte_in = flags_ff[byte_sel*8 +: 8];
                  flags_in[byte_sel*8 +: 8] = '0;
               end
               ADDR_MASK0, ADDR_MASK1, ADDR_MASK2, ADDR_MASK3:
                  rbyte_in = mask_ff[byte_sel*8 +: 8];
               ADDR_RAM_IDX:   rbyte_in = ram_idx_ff;
               ADDR_RAM_DATA: begin
                  // data comes from the RAM output register; unwritten reads zero
                  ram_hit_in = ram_in_range && ram_valid_ff[ram_addr];
                  ram_idx_in = ram_idx_ff + 8'd1;
               end
               default:        rbyte_in = '0;
            endcase
         end
         OP_WRITE: begin
            ptr_in = ptr_ff + {7'd0, autoinc_ff};
            unique case (ptr_ff)
               ADDR_MASK0, ADDR_MASK1, ADDR_MASK2, ADDR_MASK3: begin
                  mask_in[byte_sel*8 +: 8] = d;
                  irq_in = |(flags_ff & ~mask_in);
               end
               ADDR_RAIL_CTRL: begin
                  // ordered clear/set sequence
                  if (d[0]) rails_in    = '0;
                  if (d[1]) rails_in[7] = 1'b1;
                  if (d[2]) rails_in[5] = 1'b0;
                  if (d[3]) rails_in[5] = 1'b1;
                  if (d[4]) rails_in[6] = 1'b0;
                  if (d[5]) rails_in[6] = 1'b1;
                  flags_in = flags_ff | {2'd0, d[5:0] & RAIL_FLAG_BITS, 24'd0};
                  irq_in   = |(flags_in & ~mask_ff);
               end
               ADDR_RAM_IDX:  ram_idx_in = d;
               ADDR_RAM_DATA: begin
                  if (ram_in_range) begin
                     ram_we     = 1'b1;
                     ram_idx_in = ram_idx_ff + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         OP_EVENT: begin
            flags_in = flags_ff | item.event_mask;
            irq_in   = |(flags_in & ~mask_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         autoinc_ff   <= 1'b0;
         flags_ff     <= '0;
         mask_ff      <= '0;
         rails_ff     <= '0;
         ram_idx_ff   <= '0;
         ram_valid_ff <= '0;
      end else if (exec) begin
         ptr_ff     <= ptr_in;
         autoinc_ff <= autoinc_in;
         flags_ff   <= flags_in;
         mask_ff    <= mask_in;
         rails_ff   <= rails_in;
         ram_idx_ff <= ram_idx_in;
         if (ram_we) begin
            ram_valid_ff[ram_addr] <= 1'b1;
         end
      end
   end

   // scratch RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (exec && ram_we) begin
         ram_mem[ram_addr] <= d;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         ram_rd_ff <= ram_mem[ram_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         ram_hit_ff  <= ram_hit_in;
         rbyte_ff    <= rbyte_in;
         irq_ff      <= irq_in;
         rail_out_ff <= rails_in;
      end
   end

   assign result.read_byte   = ram_hit_ff ? ram_rd_ff : rbyte_ff;
   assign result.irq_request = irq_ff;
   assign result.rail_state  = rail_out_ff;

endmodule

>>> dv/tb_power_mcu_register_device_core.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Power MCU register device core testbench
// Drives register access transactions into the device and compares each
// result with a cycle-free model of the register map, the flags and the RAM.
// Random idling on both channels, a long receiver hold-off and battery level
// updates between phases.
// -----------------------------------------------------------------------------
module tb_power_mcu_register_device_core;
   import pmrd_pkg::*;

   localparam int         RAM_DEPTH    = 200;
   localparam int         LIMIT_CYCLES = 400000;
   localparam int         DRAIN_CYCLES = 4;
   localparam logic [7:0] CLOCK_REG_LO = 8'h30;   // clock registers 0x30..0x36 read as zero
   localparam logic [7:0] PTR_TOP      = 8'hFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [DATA_W-1:0] csr_wr_data;

   pmrd_req_if req_bus ();
   pmrd_rsp_if rsp_bus ();

   power_mcu_register_device_core #(
      .RAM_BYTES(RAM_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Device model state, updated when a transaction is accepted
   // ---------------------------------------------------------------------------
   logic [7:0]  dev_ptr;
   logic        dev_autoinc;
   logic [31:0] dev_flags;
   logic [31:0] dev_mask;        // 1 masks the flag
   logic [7:0]  dev_rails;
   logic [7:0]  dev_ram_idx;
   logic [7:0]  dev_battery;
   logic [7:0]  dev_ram [0:255];

   pmrd_result_type pending_results [$];

   int src_gap_pct;              // chance of an idle burst before a transaction
   int sink_stall_pct;           // chance of a ready-low burst
   int long_hold_cycles;         // picked up once by the receiver process
   int cycle_count;
   int mismatch_count;
   int results_checked;
   int read_count;
   int irq_count;
   int battery_writes;

   // OR new flags in; irq when any flag is left unmasked
   function automatic logic raise_flags(input logic [31:0] events);
      dev_flags = dev_flags | events;
      return (dev_flags & ~dev_mask) != '0;
   endfunction

   function automatic pmrd_result_type predict_access(input op_type op,
                                                      input logic [7:0] data,
                                                      input logic [31:0] events);
      pmrd_result_type res;
      logic [7:0] addr;
      res  = '0;
      addr = dev_ptr;
      case (op)
         OP_SET_PTR: begin
            dev_ptr     = data;
            dev_autoinc = !(data == NOINC_A || data == NOINC_B || data == NOINC_C ||
                            data == NOINC_D || data == NOINC_E);
         end
         OP_WRITE: begin
            dev_ptr = dev_ptr + {7'd0, dev_autoinc};
            case (addr)
               ADDR_MASK0, ADDR_MASK1, ADDR_MASK2, ADDR_MASK3: begin
                  dev_mask[{addr[1:0], 3'b000} +: 8] = data;
                  res.irq_request = raise_flags('0);
               end
               ADDR_RAIL_CTRL: begin
                  // ordered: clear all, set 7, clear 5, set 5, clear 6, set 6
                  if (data[0]) dev_rails    = '0;
                  if (data[1]) dev_rails[7] = 1'b1;
                  if (data[2]) dev_rails[5] = 1'b0;
                  if (data[3]) dev_rails[5] = 1'b1;
                  if (data[4]) dev_rails[6] = 1'b0;
                  if (data[5]) dev_rails[6] = 1'b1;
                  res.irq_request = raise_flags({2'b00, data[5:0] & RAIL_FLAG_BITS, 24'h0});
               end
               ADDR_RAM_IDX: dev_ram_idx = data;
               ADDR_RAM_DATA: begin
                  // out of range: dropped, index holds
                  if (dev_ram_idx < RAM_DEPTH) begin
                     dev_ram[dev_ram_idx] = data;
                     dev_ram_idx          = dev_ram_idx + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         OP_READ: begin
            dev_ptr = dev_ptr + {7'd0, dev_autoinc};
            read_count++;
            case (addr)
               ADDR_ID0:       res.read_byte = ID_BYTE0;
               ADDR_ID1:       res.read_byte = ID_BYTE1;
               ADDR_BATTERY:   res.read_byte = dev_battery;
               ADDR_RAIL_STAT: res.read_byte = RAIL_STAT_BASE | dev_rails;
               ADDR_FLAG0, ADDR_FLAG1, ADDR_FLAG2, ADDR_FLAG3: begin
                  // read clears the flag byte
                  res.read_byte = dev_flags[{addr[1:0], 3'b000} +: 8];
                  dev_flags[{addr[1:0], 3'b000} +: 8] = '0;
               end
               ADDR_MASK0, ADDR_MASK1, ADDR_MASK2, ADDR_MASK3:
                  res.read_byte = dev_mask[{addr[1:0], 3'b000} +: 8];
               ADDR_RAM_IDX:   res.read_byte = dev_ram_idx;
               ADDR_RAM_DATA: begin
                  // out of range reads zero but the index still moves on
                  if (dev_ram_idx < RAM_DEPTH) res.read_byte = dev_ram[dev_ram_idx];
                  dev_ram_idx = dev_ram_idx + 8'd1;
               end
               default: res.read_byte = '0;   // clock, rail control and unknown
            endcase
         end
         default: res.irq_request = raise_flags(events);
      endcase
      res.rail_state = dev_rails;
      if (res.irq_request) irq_count++;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side: one transaction, with an optional idle burst ahead of it.
   // Valid is left high on return so back-to-back transactions need no toggle.
   // ---------------------------------------------------------------------------
   task automatic send_access(input op_type op, input logic [7:0] data,
                              input logic [31:0] events);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < src_gap_pct) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.data_byte  <= data;
      req_bus.event_mask <= events;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_access(op, data, events));
   endtask

   // sender pauses until every outstanding result is back
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_battery(input logic [7:0] level);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dev_battery = level;
      battery_writes++;
   endtask

   // ---------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------

   // ID bytes, battery at reset value, a clock register, pointer wrap past 0xFF
   task automatic test_register_reads();
      send_access(OP_SET_PTR, ADDR_ID0, '0);
      send_access(OP_READ, 8'h00, '0);
      send_access(OP_READ, 8'hFF, '1);
      send_access(OP_SET_PTR, ADDR_BATTERY, '0);
      send_access(OP_READ, 8'h00, '0);
      send_access(OP_SET_PTR, CLOCK_REG_LO, '0);
      send_access(OP_READ, 8'h00, '0);
      send_access(OP_SET_PTR, PTR_TOP, '0);
      send_access(OP_WRITE, 8'hAA, '0);       // unknown register, pointer wraps to 0
      send_access(OP_READ, 8'h00, '0);
   endtask

   // all flags up, read-to-clear per byte, mask byte, single unmasked flag
   task automatic test_irq_flags_and_mask();
      send_access(OP_EVENT, 8'h00, 32'hFFFF_FFFF);
      send_access(OP_SET_PTR, ADDR_FLAG0, '0);
      repeat (4) send_access(OP_READ, 8'h00, '0);
      send_access(OP_SET_PTR, ADDR_MASK3, '0);
      send_access(OP_WRITE, 8'hFF, '0);
      send_access(OP_EVENT, 8'h00, 32'h0000_0001);
   endtask

   // every rail control bit at once, then all clears
   task automatic test_rail_control();
      send_access(OP_SET_PTR, ADDR_RAIL_CTRL, '0);
      send_access(OP_WRITE, 8'h3F, '0);
      send_access(OP_SET_PTR, ADDR_RAIL_CTRL, '0);
      send_access(OP_WRITE, 8'h15, '0);
      send_access(OP_SET_PTR, ADDR_RAIL_STAT, '0);
      send_access(OP_READ, 8'h00, '0);
   endtask

   // last RAM byte, then write and read beyond the end
   task automatic test_scratch_ram();
      send_access(OP_SET_PTR, ADDR_RAM_IDX, '0);
      send_access(OP_WRITE, 8'(RAM_DEPTH - 1), '0);
      send_access(OP_WRITE, 8'h5A, '0);       // pointer now on RAM data
      send_access(OP_SET_PTR, ADDR_RAM_DATA, '0);
      send_access(OP_WRITE, 8'h11, '0);       // out of range, dropped
      send_access(OP_READ, 8'h00, '0);        // out of range, zero
      send_access(OP_SET_PTR, ADDR_RAM_IDX, '0);
      send_access(OP_READ, 8'h00, '0);
   endtask

   task automatic test_battery_setting();
      logic [7:0] levels [4];
      levels = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), BATTERY_RESET};
      foreach (levels[i]) begin
         write_battery(levels[i]);
         send_access(OP_SET_PTR, ADDR_BATTERY, '0);
         send_access(OP_READ, 8'h00, '0);
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      src_gap_pct      = 0;
      long_hold_cycles = 80;
      send_access(OP_SET_PTR, ADDR_FLAG0, '0);
      repeat (40) send_access(op_type'($urandom_range(0, 3)), 8'($urandom), $urandom);
      wait_until_idle();
   endtask

   // ---------------------------------------------------------------------------
   // Random traffic: mostly pointer load followed by a short access burst
   // ---------------------------------------------------------------------------
   task automatic run_random_traffic(input int n_items);
      int sent;
      int pick;
      logic [7:0] addr;
      logic [7:0] data;
      logic [31:0] events;
      op_type op;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            case ($urandom_range(0, 3))
               0:       events = '0;
               1:       events = '1;
               2:       events = 32'd1 << $urandom_range(0, 31);
               default: events = $urandom;
            endcase
            send_access(OP_EVENT, 8'($urandom), events);
            sent++;
         end else if (pick < 88) begin
            case ($urandom_range(0, 15))
               0:       addr = ($urandom_range(0, 1)) ? ADDR_ID0 : ADDR_ID1;
               1:       addr = ADDR_BATTERY;
               2:       addr = ADDR_RAIL_STAT;
               3:       addr = ADDR_FLAG0 + 8'($urandom_range(0, 3));
               4:       addr = ADDR_MASK0 + 8'($urandom_range(0, 3));
               5, 6:    addr = ADDR_RAIL_CTRL;
               7, 8:    addr = ADDR_RAM_IDX;
               9, 10:   addr = ADDR_RAM_DATA;
               11:      addr = NOINC_A;
               12: begin
                  case ($urandom_range(0, 2))
                     0:       addr = NOINC_B;
                     1:       addr = NOINC_C;
                     default: addr = NOINC_E;
                  endcase
               end
               13:      addr = CLOCK_REG_LO + 8'($urandom_range(0, 6));
               14:      addr = 8'($urandom);
               default: addr = PTR_TOP - 8'($urandom_range(0, 2));
            endcase
            send_access(OP_SET_PTR, addr, $urandom);
            sent++;
            repeat ($urandom_range(1, 6)) begin
               op   = ($urandom_range(0, 1)) ? OP_READ : OP_WRITE;
               data = 8'($urandom);
               // keep RAM index mostly in range, with the boundary hit often
               if (dev_ptr == ADDR_RAM_IDX) begin
                  case ($urandom_range(0, 3))
                     0, 1:    data = 8'($urandom_range(0, RAM_DEPTH - 1));
                     2:       data = 8'($urandom_range(RAM_DEPTH - 2, RAM_DEPTH + 1));
                     default: data = 8'($urandom);
                  endcase
               end
               // mask bytes: all clear or all set half the time
               if (dev_ptr[7:2] == ADDR_MASK0[7:2] && $urandom_range(0, 1))
                  data = ($urandom_range(0, 1)) ? 8'h00 : 8'hFF;
               send_access(op, data, $urandom);
               sent++;
            end
         end else begin
            send_access(op_type'($urandom_range(0, 3)), 8'($urandom), $urandom);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: random ready-low bursts, plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      int hold;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            hold             = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: every accepted result against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      pmrd_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR @%0t: result with nothing expected (rd=%02h irq=%0b rail=%02h)",
                        $time, rsp_bus.read_byte, rsp_bus.irq_request, rsp_bus.rail_state);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.read_byte !== want.read_byte ||
                rsp_bus.irq_request !== want.irq_request ||
                rsp_bus.rail_state !== want.rail_state) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR @%0t: result %0d exp rd=%02h irq=%0b rail=%02h,",
                            " got rd=%02h irq=%0b rail=%02h"},
                           $time, results_checked, want.read_byte, want.irq_request,
                           want.rail_state, rsp_bus.read_byte, rsp_bus.irq_request,
                           rsp_bus.rail_state);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("FAIL power_mcu_register_device_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_SET_PTR;
      req_bus.data_byte  <= '0;
      req_bus.event_mask <= '0;
      read_count       = 0;
      irq_count        = 0;
      battery_writes   = 0;
      long_hold_cycles = 0;
      src_gap_pct      = 20;
      sink_stall_pct   = 20;

      // model reset state
      dev_ptr     = '0;
      dev_autoinc = 1'b0;
      dev_flags   = '0;
      dev_mask    = '0;
      dev_rails   = '0;
      dev_ram_idx = '0;
      dev_battery = BATTERY_RESET;
      foreach (dev_ram[i]) dev_ram[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reads();
      test_irq_flags_and_mask();
      test_rail_control();
      test_scratch_ram();
      test_battery_setting();

      // random phases with varying idle pressure
      src_gap_pct = 25; sink_stall_pct = 25;
      run_random_traffic(400);
      src_gap_pct = 0;  sink_stall_pct = 0;
      run_random_traffic(150);
      src_gap_pct = 60; sink_stall_pct = 10;
      run_random_traffic(200);
      test_backpressure();
      write_battery(8'($urandom));
      src_gap_pct = 10; sink_stall_pct = 60;
      run_random_traffic(300);

      // last part without any idling
      src_gap_pct = 0;  sink_stall_pct = 0;
      run_random_traffic(250);

      wait_until_idle();
      repeat (10) @(posedge clock);

      $display("checked %0d transactions: %0d reads, %0d with irq raised", results_checked,
               read_count, irq_count);
      $display("%0d battery level updates, %0d mismatches", battery_writes, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS power_mcu_register_device_core");
      end else begin
         $display("FAIL power_mcu_register_device_core");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/pmrd_pkg.sv
src/pmrd_req_if.sv
src/pmrd_rsp_if.sv
src/pmrd_regfile.sv
src/power_mcu_register_device_core.sv
dv/tb_power_mcu_register_device_core.sv
